/* rtl/lptb_pkg.sv */
// Package for the LED pulse-train blinker: phase codes, register indexes and widths.
package lptb_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned PHASE_W  = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 16;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE     = 3'd0,
      PH_TURN_ON  = 3'd1,
      PH_ON       = 3'd2,
      PH_TURN_OFF = 3'd3,
      PH_OFF      = 3'd4,
      PH_CHECK    = 3'd5,
      PH_PAUSE    = 3'd6
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_DURATION    = 2'd0,
      CSR_OFF_DURATION   = 2'd1,
      CSR_PAUSE_DURATION = 2'd2,
      CSR_PULSE_TARGET   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0] pulses_done;
      logic [PHASE_W-1:0] phase_out;
      logic               led_level;
   } result_type;

endpackage

/* rtl/led_pulse_train_blinker_top.sv */
// LED pulse-train blinker: phase machine with registered result and skid stage.
// Each result is registered in the output slot, or in the skid slot while an earlier result waits.
// One request per cycle while the skid slot is empty; the phase update is a 32-bit subtract and compare.
// A skid register keeps req_tready high for one request while a result waits.
// Synchronous active-high reset clears phase, counter, start time, LED, registers
// and the valid flags of both result slots.
module led_pulse_train_blinker_top
   import lptb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] now_ms
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] led_level, [3:1] phase_out, [11:4] pulses_done
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TIME_W-1:0]  on_dur_ff, off_dur_ff, pause_dur_ff;
   logic [COUNT_W-1:0] target_ff;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] pulse_cnt_ff, pulse_cnt_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic               drive_ff, drive_in;

   logic               out_valid_ff, skid_valid_ff;
   result_type         out_data_ff, skid_data_ff;
   result_type         result;

   logic               accept, pop;
   logic [TIME_W-1:0]  now, elapsed;

   assign now        = req_tdata[TIME_W-1:0];
   assign elapsed    = now - start_ff;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_dur_ff    <= '0;
         off_dur_ff   <= '0;
         pause_dur_ff <= '0;
         target_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ON_DURATION:    on_dur_ff    <= csr_wdata[TIME_W-1:0];
            CSR_OFF_DURATION:   off_dur_ff   <= csr_wdata[TIME_W-1:0];
            CSR_PAUSE_DURATION: pause_dur_ff <= csr_wdata[TIME_W-1:0];
            CSR_PULSE_TARGET:   target_ff    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      pulse_cnt_in = pulse_cnt_ff;
      start_in     = start_ff;
      drive_in     = drive_ff;
      unique case (phase_ff)
         PH_TURN_ON: begin
            drive_in     = 1'b1;
            pulse_cnt_in = pulse_cnt_ff + COUNT_W'(1);
            start_in     = now;
            phase_in     = PH_ON;
         end
         PH_ON: begin
            if (elapsed >= on_dur_ff) phase_in = PH_TURN_OFF;
         end
         PH_TURN_OFF: begin
            drive_in = 1'b0;
            start_in = now;
            phase_in = PH_OFF;
         end
         PH_OFF: begin
            if (elapsed >= off_dur_ff) phase_in = PH_CHECK;
         end
         PH_CHECK: begin
            if (pulse_cnt_ff >= target_ff) begin
               pulse_cnt_in = '0;
               start_in     = now;
               phase_in     = PH_PAUSE;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_PAUSE: begin
            if (elapsed >= pause_dur_ff) phase_in = PH_IDLE;
         end
         default: phase_in = PH_TURN_ON;
      endcase
   end

   always_comb begin
      result.led_level   = drive_in;
      result.phase_out   = phase_in;
      result.pulses_done = pulse_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pulse_cnt_ff <= '0;
         start_ff     <= '0;
         drive_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         pulse_cnt_ff <= pulse_cnt_in;
         start_ff     <= start_in;
         drive_ff     <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_data_ff);

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot full while output slot empty");

   a_turn_on_lights: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_TURN_ON |=> drive_ff && phase_ff == PH_ON)
      else $error("turn-on step did not light the LED");

   a_pause_clears: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_CHECK && pulse_cnt_ff >= target_ff
      |=> pulse_cnt_ff == '0 && phase_ff == PH_PAUSE)
      else $error("burst end did not clear the pulse count");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !pop |=> skid_valid_ff && $stable(skid_data_ff))
      else $error("waiting result in skid slot lost");
`endif

endmodule
